// ----- rtl/core/cfs_pkg.sv -----
// Package for the CAN base frame serializer.
// Holds the frame constants, the command type passed from front to back, and item codes.
// No dependencies.
package cfs_pkg;

    localparam int MAX_DATA_BYTES = 8;
    localparam int STUFF_RUN      = 5;
    localparam int TRAILER_ONES   = 13;
    localparam int CRC_BITS       = 15;
    localparam int HEADER_BITS    = 19;
    localparam int DATA_BITS      = 8;
    localparam int ID_W           = 11;
    localparam int LEN_W          = 4;

    localparam logic [CRC_BITS-1:0] CRC_POLY = 15'h4599;

    localparam int RUN_W = $clog2(STUFF_RUN + 1);
    localparam int CNT_W = $clog2(HEADER_BITS);

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_DATA   = 1'b1;

    typedef struct packed {
        logic                   hdr;
        logic [HEADER_BITS-1:0] bits;
        logic                   fin;
    } cmd_t;

endpackage

// ----- rtl/core/cfs_item_if.sv -----
// Input channel of the CAN base frame serializer: one header or data item per transfer.
// Depends on cfs_pkg for field widths.
interface cfs_item_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [cfs_pkg::ID_W-1:0]     ident;
    logic [cfs_pkg::LEN_W-1:0]    length_code;
    logic [cfs_pkg::DATA_BITS-1:0] data_byte;

    modport source (output valid, output mode, output ident, output length_code,
                    output data_byte, input ready);
    modport sink   (input valid, input mode, input ident, input length_code,
                    input data_byte, output ready);
endinterface

// ----- rtl/core/cfs_bit_if.sv -----
// Output channel of the CAN base frame serializer: one bus bit per transfer.
// No dependencies.
interface cfs_bit_if;
    logic valid;
    logic ready;
    logic line_bit;
    logic stuffed;
    logic frame_end;
    logic last;

    modport source (output valid, output line_bit, output stuffed, output frame_end,
                    output last, input ready);
    modport sink   (input valid, input line_bit, input stuffed, input frame_end,
                    input last, output ready);
endinterface

// ----- rtl/core/cfs_cmd_fifo.sv -----
// Two-entry command queue between the item front end and the bit engine.
// Depends on cfs_pkg for cmd_t and the queue depth.
module cfs_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfs_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output cfs_pkg::cmd_t pop_cmd,
    output logic          empty
);

    cfs_pkg::cmd_t                      mem [cfs_pkg::CMD_DEPTH];
    logic [cfs_pkg::CMD_PTR_W-1:0]      wr_ptr_reg;
    logic [cfs_pkg::CMD_PTR_W-1:0]      rd_ptr_reg;
    logic [cfs_pkg::CMD_CNT_W-1:0]      count_reg;

    assign full    = (count_reg == cfs_pkg::CMD_CNT_W'(cfs_pkg::CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/cfs_front.sv -----
// Front end: accepts items, tracks the open frame and the bytes still due,
// drops stray data bytes and queues one command per kept item. Depends on cfs_pkg.
module cfs_front (
    input  logic          clk,
    input  logic          rst_n,
    cfs_item_if.sink      item,
    output logic          push,
    output cfs_pkg::cmd_t push_cmd,
    input  logic          full
);

    logic                          frame_open_reg;
    logic                          frame_open_next;
    logic [cfs_pkg::LEN_W-1:0]     bytes_left_reg;
    logic [cfs_pkg::LEN_W-1:0]     bytes_left_next;
    logic [cfs_pkg::LEN_W-1:0]     len_sat;
    logic                          take;

    assign item.ready = !full;
    assign take       = item.valid && !full;

    assign len_sat = (item.length_code > cfs_pkg::LEN_W'(cfs_pkg::MAX_DATA_BYTES))
                   ? cfs_pkg::LEN_W'(cfs_pkg::MAX_DATA_BYTES) : item.length_code;

    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        push            = 1'b0;
        push_cmd.hdr    = 1'b0;
        push_cmd.bits   = {item.data_byte, (cfs_pkg::HEADER_BITS - cfs_pkg::DATA_BITS)'(0)};
        push_cmd.fin    = 1'b0;
        if (take)
        begin
            if (item.mode == cfs_pkg::MODE_HEADER)
            begin
                push            = 1'b1;
                push_cmd.hdr    = 1'b1;
                push_cmd.bits   = {1'b0, item.ident, 3'b000, len_sat};
                push_cmd.fin    = (len_sat == '0);
                frame_open_next = (len_sat != '0);
                bytes_left_next = len_sat;
            end
            else if (frame_open_reg)
            begin
                push         = 1'b1;
                push_cmd.fin = (bytes_left_reg <= cfs_pkg::LEN_W'(1));
                if (bytes_left_reg <= cfs_pkg::LEN_W'(1))
                begin
                    frame_open_next = 1'b0;
                    bytes_left_next = '0;
                end
                else
                begin
                    bytes_left_next = bytes_left_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= '0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// ----- rtl/core/cfs_back.sv -----
// Bit engine: shifts out queued header and data bits with CRC-15 and bit stuffing,
// then the CRC field and the recessive trailer. Depends on cfs_pkg.
module cfs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  cfs_pkg::cmd_t pop_cmd,
    input  logic          empty,
    output logic          pop,
    cfs_bit_if.source     bits
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_CRC   = 2'd2;
    localparam logic [1:0] ST_TRAIL = 2'd3;

    logic [1:0]                          state_reg,      state_next;
    logic [cfs_pkg::HEADER_BITS-1:0]     sh_reg,         sh_next;
    logic [cfs_pkg::CNT_W-1:0]           cnt_reg,        cnt_next;
    logic                                hdr_reg,        hdr_next;
    logic                                fin_reg,        fin_next;
    logic [cfs_pkg::CRC_BITS-1:0]        crc_reg,        crc_next;
    logic [cfs_pkg::RUN_W-1:0]           run_cnt_reg,    run_cnt_next;
    logic                                run_val_reg,    run_val_next;
    logic                                stuff_pend_reg, stuff_pend_next;
    logic                                stuff_last_reg, stuff_last_next;
    logic                                valid_reg,      valid_next;
    logic                                line_bit_reg,   line_bit_next;
    logic                                stuffed_reg,    stuffed_next;
    logic                                frame_end_reg,  frame_end_next;
    logic                                last_reg,       last_next;

    logic                                out_free;
    logic                                cur_bit;
    logic [cfs_pkg::RUN_W-1:0]           run_new;
    logic                                stuff_now;
    logic                                final_shift;
    logic [cfs_pkg::CNT_W-1:0]           shift_end;

    assign out_free  = !valid_reg || bits.ready;
    assign cur_bit   = (state_reg == ST_CRC) ? crc_reg[cfs_pkg::CRC_BITS-1]
                                             : sh_reg[cfs_pkg::HEADER_BITS-1];
    assign run_new   = (run_cnt_reg != '0 && cur_bit == run_val_reg)
                     ? run_cnt_reg + 1'b1 : cfs_pkg::RUN_W'(1);
    assign stuff_now = (run_new == cfs_pkg::RUN_W'(cfs_pkg::STUFF_RUN));
    assign shift_end = hdr_reg ? cfs_pkg::CNT_W'(cfs_pkg::HEADER_BITS - 1)
                               : cfs_pkg::CNT_W'(cfs_pkg::DATA_BITS - 1);
    assign final_shift = (cnt_reg == shift_end);
    assign pop = (state_reg == ST_IDLE) && !stuff_pend_reg && !empty;

    always_comb
    begin
        state_next      = state_reg;
        sh_next         = sh_reg;
        cnt_next        = cnt_reg;
        hdr_next        = hdr_reg;
        fin_next        = fin_reg;
        crc_next        = crc_reg;
        run_cnt_next    = run_cnt_reg;
        run_val_next    = run_val_reg;
        stuff_pend_next = stuff_pend_reg;
        stuff_last_next = stuff_last_reg;
        valid_next      = valid_reg && !bits.ready;
        line_bit_next   = line_bit_reg;
        stuffed_next    = stuffed_reg;
        frame_end_next  = frame_end_reg;
        last_next       = last_reg;

        if (out_free && stuff_pend_reg)
        begin
            valid_next      = 1'b1;
            line_bit_next   = !run_val_reg;
            stuffed_next    = 1'b1;
            frame_end_next  = 1'b0;
            last_next       = stuff_last_reg;
            run_val_next    = !run_val_reg;
            run_cnt_next    = cfs_pkg::RUN_W'(1);
            stuff_pend_next = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        sh_next    = pop_cmd.bits;
                        hdr_next   = pop_cmd.hdr;
                        fin_next   = pop_cmd.fin;
                        cnt_next   = '0;
                        state_next = ST_SHIFT;
                        if (pop_cmd.hdr)
                        begin
                            crc_next     = '0;
                            run_cnt_next = '0;
                            run_val_next = 1'b0;
                        end
                    end
                end
                ST_SHIFT, ST_CRC:
                begin
                    if (out_free)
                    begin
                        valid_next      = 1'b1;
                        line_bit_next   = cur_bit;
                        stuffed_next    = 1'b0;
                        frame_end_next  = 1'b0;
                        run_val_next    = cur_bit;
                        run_cnt_next    = run_new;
                        stuff_pend_next = stuff_now;
                        cnt_next        = cnt_reg + 1'b1;
                        if (state_reg == ST_SHIFT)
                        begin
                            last_next       = final_shift && !fin_reg && !stuff_now;
                            stuff_last_next = final_shift && !fin_reg;
                            sh_next         = sh_reg << 1;
                            crc_next        = (crc_reg << 1)
                                            ^ ((cur_bit ^ crc_reg[cfs_pkg::CRC_BITS-1])
                                               ? cfs_pkg::CRC_POLY : '0);
                            if (final_shift)
                            begin
                                cnt_next   = '0;
                                state_next = fin_reg ? ST_CRC : ST_IDLE;
                            end
                        end
                        else
                        begin
                            last_next       = 1'b0;
                            stuff_last_next = 1'b0;
                            crc_next        = crc_reg << 1;
                            if (cnt_reg == cfs_pkg::CNT_W'(cfs_pkg::CRC_BITS - 1))
                            begin
                                cnt_next   = '0;
                                state_next = ST_TRAIL;
                            end
                        end
                    end
                end
                ST_TRAIL:
                begin
                    if (out_free)
                    begin
                        valid_next     = 1'b1;
                        line_bit_next  = 1'b1;
                        stuffed_next   = 1'b0;
                        frame_end_next = (cnt_reg == cfs_pkg::CNT_W'(cfs_pkg::TRAILER_ONES - 1));
                        last_next      = frame_end_next;
                        cnt_next       = cnt_reg + 1'b1;
                        if (frame_end_next)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg        <= sh_next;
        cnt_reg       <= cnt_next;
        hdr_reg       <= hdr_next;
        fin_reg       <= fin_next;
        crc_reg       <= crc_next;
        line_bit_reg  <= line_bit_next;
        stuffed_reg   <= stuffed_next;
        frame_end_reg <= frame_end_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            run_cnt_reg    <= '0;
            run_val_reg    <= 1'b0;
            stuff_pend_reg <= 1'b0;
            stuff_last_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            run_cnt_reg    <= run_cnt_next;
            run_val_reg    <= run_val_next;
            stuff_pend_reg <= stuff_pend_next;
            stuff_last_reg <= stuff_last_next;
            valid_reg      <= valid_next;
        end
    end

    assign bits.valid     = valid_reg;
    assign bits.line_bit  = line_bit_reg;
    assign bits.stuffed   = stuffed_reg;
    assign bits.frame_end = frame_end_reg;
    assign bits.last      = last_reg;

endmodule

// ----- rtl/core/can_frame_serializer.sv -----
// CAN base data frame serializer, top level. A header item (mode 0) opens a frame and
// sends SOF, the identifier, three dominant bits and the DLC; each data item (mode 1)
// sends one byte MSB first; the item that closes the frame also sends the CRC-15 field
// and thirteen recessive ones, the last of them flagged frame_end. Bits leave one per
// transfer, one per cycle when the sink is ready and no command is being fetched; stuff
// bits are inserted after five equal bits from SOF through the CRC. The bit engine
// fetches each command from its two-entry queue in its idle state, shifts out the bits
// of the item, and for a closing item goes on to the CRC field and then the trailer. The
// front end keeps accepting items until that queue holds two commands. Data items that
// arrive with no frame open are dropped. The block depends on cfs_pkg, cfs_item_if,
// cfs_bit_if, cfs_front, cfs_cmd_fifo and cfs_back.
module can_frame_serializer (
    input  logic      clk,
    input  logic      rst_n,
    cfs_item_if.sink  item_ch,
    cfs_bit_if.source bit_ch
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    cfs_pkg::cmd_t push_cmd;
    cfs_pkg::cmd_t pop_cmd;

    cfs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full)
    );

    cfs_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    cfs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .pop_cmd (pop_cmd),
        .empty   (empty),
        .pop     (pop),
        .bits    (bit_ch)
    );

endmodule

// ----- rtl/core/cfs_checker.sv -----
// Port-level checks for the CAN base frame serializer output channel.
// Bound to can_frame_serializer; depends on nothing else.
module cfs_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic line_bit,
    input logic stuffed,
    input logic frame_end,
    input logic last
);

    logic prev_bit_reg;
    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_bit_reg <= 1'b0;
            seen_reg     <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            prev_bit_reg <= line_bit;
            seen_reg     <= 1'b1;
        end
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Output valid dropped before its transfer.");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> last && line_bit && !stuffed)
        else $error("Frame end bit is not a final recessive bit.");

    a_stuff_flips: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && stuffed |-> seen_reg && (line_bit != prev_bit_reg))
        else $error("Stuff bit does not complement the previous bit.");

    a_no_double_stuff: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && stuffed |=> !(out_valid && stuffed))
        else $error("Two stuff bits in a row.");

endmodule

bind can_frame_serializer cfs_checker u_cfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (bit_ch.valid),
    .out_ready (bit_ch.ready),
    .line_bit  (bit_ch.line_bit),
    .stuffed   (bit_ch.stuffed),
    .frame_end (bit_ch.frame_end),
    .last      (bit_ch.last)
);

// ----- tb/sv/tb_can_frame_serializer.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for can_frame_serializer: directed and random header and data
// items in, every serialized bus bit out, compared with a bit-level frame predictor.
// Depends on cfs_pkg, cfs_item_if, cfs_bit_if and the serializer RTL.
module tb_can_frame_serializer;

    localparam int RANDOM_ITEMS   = 300;
    localparam int HOLD_AT        = 60;
    localparam int HOLD_CYCLES    = 500;
    localparam int QUIET_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RESERVED_ZEROS = 3;

    typedef struct packed {
        logic                          mode;
        logic [cfs_pkg::ID_W-1:0]      ident;
        logic [cfs_pkg::LEN_W-1:0]     length_code;
        logic [cfs_pkg::DATA_BITS-1:0] data_byte;
        logic                          no_bits;
    } stim_item_t;

    typedef struct packed {
        logic line_bit;
        logic stuffed;
        logic frame_end;
        logic last;
    } bus_bit_t;

    logic clk;
    logic rst_n;

    cfs_item_if item_ch ();
    cfs_bit_if  bit_ch ();

    can_frame_serializer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item_ch(item_ch),
        .bit_ch (bit_ch)
    );

    // Rows marked no_bits are data bytes with no frame open and must produce nothing.
    stim_item_t directed_rows [25] = '{
        '{cfs_pkg::MODE_DATA,   11'h7FF, 4'hF, 8'hFF, 1'b1},
        '{cfs_pkg::MODE_HEADER, 11'h000, 4'h0, 8'h00, 1'b0},
        '{cfs_pkg::MODE_HEADER, 11'h7FF, 4'h8, 8'hFF, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'h00, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h7FF, 4'hF, 8'hFF, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'hAA, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'h55, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'h80, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'h01, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'h7F, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'hFE, 1'b0},
        '{cfs_pkg::MODE_HEADER, 11'h555, 4'hF, 8'h00, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h2AA, 4'h5, 8'h0F, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'hF0, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'h33, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'hCC, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'h00, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'h00, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'hFF, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'hFF, 1'b0},
        '{cfs_pkg::MODE_HEADER, 11'h2AA, 4'h2, 8'hFF, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'h3C, 1'b0},
        '{cfs_pkg::MODE_HEADER, 11'h123, 4'h1, 8'h00, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'hC3, 1'b0},
        '{cfs_pkg::MODE_DATA,   11'h000, 4'h0, 8'h5A, 1'b1}
    };

    stim_item_t stim [$];
    bus_bit_t   bits_due [$];
    bus_bit_t   item_bits [$];
    int         items_accepted = 0;
    int         fail_count = 0;
    bit         send_gaps_on = 1'b1;
    bit         recv_gaps_on = 1'b1;

    logic                         tx_open = 1'b0;
    logic [cfs_pkg::LEN_W-1:0]    tx_bytes_left = '0;
    logic [cfs_pkg::CRC_BITS-1:0] tx_crc = '0;
    int                           tx_run_len = 0;
    logic                         tx_run_val = 1'b0;

    function automatic int draw_pause(inout bit gaps_on);
        if ($urandom_range(0, 15) == 0)
        begin
            gaps_on = !gaps_on;
        end
        return gaps_on ? $urandom_range(0, 7) : 0;
    endfunction

    function automatic stim_item_t random_item(logic mode);
        stim_item_t it;
        it.mode        = mode;
        it.ident       = cfs_pkg::ID_W'($urandom_range(0, 2047));
        it.length_code = cfs_pkg::LEN_W'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
            0: it.data_byte = 8'h00;
            1: it.data_byte = 8'hFF;
            default: it.data_byte = cfs_pkg::DATA_BITS'($urandom);
        endcase
        it.no_bits = 1'b0;
        return it;
    endfunction

    // Sends one bit of the stuffed region, updating the run of equal bits and, when into_crc is set, the CRC.
    function automatic void put_field_bit(logic b, logic into_crc);
        logic top;
        item_bits.push_back('{b, 1'b0, 1'b0, 1'b0});
        if (into_crc)
        begin
            top    = tx_crc[cfs_pkg::CRC_BITS-1];
            tx_crc = {tx_crc[cfs_pkg::CRC_BITS-2:0], 1'b0};
            if (b ^ top)
            begin
                tx_crc = tx_crc ^ cfs_pkg::CRC_POLY;
            end
        end
        if (tx_run_len > 0 && b == tx_run_val)
        begin
            tx_run_len++;
        end
        else
        begin
            tx_run_val = b;
            tx_run_len = 1;
        end
        if (tx_run_len >= cfs_pkg::STUFF_RUN)
        begin
            tx_run_val = ~tx_run_val;
            item_bits.push_back('{tx_run_val, 1'b1, 1'b0, 1'b0});
            tx_run_len = 1;
        end
    endfunction

    function automatic void close_frame();
        logic [cfs_pkg::CRC_BITS-1:0] crc_snap;
        crc_snap = tx_crc;
        for (int i = cfs_pkg::CRC_BITS - 1; i >= 0; i--)
        begin
            put_field_bit(crc_snap[i], 1'b0);
        end
        for (int i = 0; i < cfs_pkg::TRAILER_ONES; i++)
        begin
            item_bits.push_back('{1'b1, 1'b0, (i == cfs_pkg::TRAILER_ONES - 1), 1'b0});
        end
        tx_open       = 1'b0;
        tx_bytes_left = '0;
    endfunction

    function automatic void forecast_bits(stim_item_t it);
        logic [cfs_pkg::LEN_W-1:0] count;
        bus_bit_t                  b;
        int                        n;
        item_bits.delete();
        if (it.mode == cfs_pkg::MODE_HEADER)
        begin
            count = it.length_code;
            if (count > cfs_pkg::MAX_DATA_BYTES)
            begin
                count = cfs_pkg::LEN_W'(cfs_pkg::MAX_DATA_BYTES);
            end
            tx_crc        = '0;
            tx_run_len    = 0;
            tx_run_val    = 1'b0;
            tx_open       = 1'b1;
            tx_bytes_left = count;
            put_field_bit(1'b0, 1'b1);
            for (int i = cfs_pkg::ID_W - 1; i >= 0; i--)
            begin
                put_field_bit(it.ident[i], 1'b1);
            end
            repeat (RESERVED_ZEROS) put_field_bit(1'b0, 1'b1);
            for (int i = cfs_pkg::LEN_W - 1; i >= 0; i--)
            begin
                put_field_bit(count[i], 1'b1);
            end
            if (tx_bytes_left == 0)
            begin
                close_frame();
            end
        end
        else if (tx_open)
        begin
            for (int i = cfs_pkg::DATA_BITS - 1; i >= 0; i--)
            begin
                put_field_bit(it.data_byte[i], 1'b1);
            end
            if (tx_bytes_left > 0)
            begin
                tx_bytes_left--;
            end
            if (tx_bytes_left == 0)
            begin
                close_frame();
            end
        end
        n = item_bits.size();
        for (int i = 0; i < n; i++)
        begin
            b      = item_bits[i];
            b.last = (i == n - 1);
            bits_due.push_back(b);
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : run_control
        stim_item_t hdr;
        int         counted;
        int         pick;
        int         nbytes;
        rst_n <= 1'b0;
        foreach (directed_rows[i])
        begin
            stim.push_back(directed_rows[i]);
        end
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
            begin
                stim.push_back(random_item(cfs_pkg::MODE_DATA));
            end
            else
            begin
                hdr = random_item(cfs_pkg::MODE_HEADER);
                if ($urandom_range(0, 7) == 0)
                begin
                    hdr.length_code = cfs_pkg::LEN_W'($urandom_range(9, 15));
                end
                else
                begin
                    hdr.length_code = cfs_pkg::LEN_W'($urandom_range(0,
                                                      cfs_pkg::MAX_DATA_BYTES));
                end
                stim.push_back(hdr);
                counted++;
                nbytes = (hdr.length_code > cfs_pkg::MAX_DATA_BYTES)
                       ? cfs_pkg::MAX_DATA_BYTES : int'(hdr.length_code);
                // A cut-short frame is left open and the next header abandons it.
                if (pick == 1 && nbytes > 0)
                begin
                    nbytes = $urandom_range(0, nbytes - 1);
                end
                repeat (nbytes)
                begin
                    stim.push_back(random_item(cfs_pkg::MODE_DATA));
                    counted++;
                end
            end
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (items_accepted < stim.size())
        begin
            @(posedge clk);
        end
        while (bits_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin : feed_items
        int idx;
        int gap;
        item_ch.valid       <= 1'b0;
        item_ch.mode        <= cfs_pkg::MODE_HEADER;
        item_ch.ident       <= '0;
        item_ch.length_code <= '0;
        item_ch.data_byte   <= '0;
        idx = 0;
        gap = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (item_ch.valid && item_ch.ready)
                begin
                    if (!stim[idx].no_bits)
                    begin
                        forecast_bits(stim[idx]);
                    end
                    idx++;
                    items_accepted = idx;
                    gap = draw_pause(send_gaps_on);
                end
                if (idx < stim.size() && gap == 0)
                begin
                    item_ch.valid       <= 1'b1;
                    item_ch.mode        <= stim[idx].mode;
                    item_ch.ident       <= stim[idx].ident;
                    item_ch.length_code <= stim[idx].length_code;
                    item_ch.data_byte   <= stim[idx].data_byte;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                    if (gap > 0)
                    begin
                        gap--;
                    end
                end
            end
        end
    end

    initial
    begin : collect_bits
        int       gap;
        int       hold_left;
        bit       hold_done;
        bus_bit_t got;
        bus_bit_t want;
        bit_ch.ready <= 1'b0;
        gap       = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (bit_ch.valid && bit_ch.ready)
            begin
                got = '{bit_ch.line_bit, bit_ch.stuffed, bit_ch.frame_end, bit_ch.last};
                if (bits_due.size() == 0)
                begin
                    $error("unexpected bit transfer: line_bit %0b stuffed %0b %s %0b last %0b",
                           got.line_bit, got.stuffed, "frame_end", got.frame_end,
                           got.last);
                    fail_count++;
                end
                else
                begin
                    want = bits_due.pop_front();
                    if (got.line_bit !== want.line_bit)
                    begin
                        $error("line_bit: expected %0b, got %0b", want.line_bit, got.line_bit);
                        fail_count++;
                    end
                    if (got.stuffed !== want.stuffed)
                    begin
                        $error("stuffed: expected %0b, got %0b", want.stuffed, got.stuffed);
                        fail_count++;
                    end
                    if (got.frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        fail_count++;
                    end
                end
                gap = draw_pause(recv_gaps_on);
            end
            if (!hold_done && items_accepted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                bit_ch.ready <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                bit_ch.ready <= 1'b0;
            end
            else
            begin
                bit_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (bit_ch.valid && bit_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

endmodule
